@@ hw/rtl/utf8_to_latin1_transcoder_macros.svh @@
// Assertion macros for the transcoder RTL.
`ifndef UTF8_TO_LATIN1_TRANSCODER_MACROS_SVH
`define UTF8_TO_LATIN1_TRANSCODER_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define U2L_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2l assertion failed");

// Checks that cons holds in the cycle after ante.
`define U2L_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2l assertion failed");

`endif

@@ hw/rtl/u2l_pkg.sv @@
// Types and constants shared by the UTF-8 to Latin-1 transcoder.
`default_nettype none
package u2l_pkg;

    localparam int unsigned RES_SLOTS = 3;

    localparam logic [1:0] MODE_STRICT  = 2'd0;
    localparam logic [1:0] MODE_IGNORE  = 2'd1;
    localparam logic [1:0] MODE_REPLACE = 2'd2;

    localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
    localparam logic [31:0] LATIN1_MAX = 32'd255;
    localparam logic [7:0]  QUESTION   = 8'h3F;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] acc;
        logic        pending;
        logic        halted;
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/utf8_to_latin1_transcoder.sv @@
// A byte is registered at the input, decoded by u2l_step, and its results are held in
// the result register, from which they are output. Throughput: one byte per cycle
// while each byte gives at most one result and the output is not stalled; a byte that
// gives two or three results holds the input stage for that many output transfers.
// Reset (synchronous, active low) clears the decode state, the mode and both stages.
`default_nettype none
`include "utf8_to_latin1_transcoder_macros.svh"
module utf8_to_latin1_transcoder
    import u2l_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_data
);

    logic                      r_in_valid;
    t_in_item                  r_in;
    t_state                    r_state;
    t_state                    n_state;
    logic [1:0]                r_mode;
    t_out_item [RES_SLOTS-1:0] r_res;
    t_out_item [RES_SLOTS-1:0] n_res;
    logic [1:0]                r_cnt;
    logic [1:0]                n_cnt;
    logic [1:0]                r_idx;
    logic                      buf_free;
    logic                      consume;
    logic                      in_xfer;
    logic                      out_xfer;

    u2l_step u_step (
        .i_state   (r_state),
        .i_item    (r_in),
        .i_mode    (r_mode),
        .o_next    (n_state),
        .o_results (n_res),
        .o_count   (n_cnt)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_idx != r_cnt);
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign buf_free    = (r_idx == r_cnt) || (((r_idx + 2'd1) == r_cnt) && !i_out_stall);
    assign consume     = r_in_valid && buf_free;
    assign o_in_stall  = r_in_valid && !buf_free;
    assign in_xfer     = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_out_item = r_res[0];
            2'd1:    o_out_item = r_res[1];
            2'd2:    o_out_item = r_res[2];
            default: o_out_item = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_mode     <= MODE_STRICT;
            r_cnt      <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_state <= n_state;
                r_cnt   <= n_cnt;
                r_idx   <= '0;
            end else if (out_xfer) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
        if (consume) begin
            r_res <= n_res;
        end
    end

    `U2L_ASSERT_NEXT(a_end_clears_state, i_clk, i_rst_n, consume && r_in.end_of_string,
        r_state == '0)
    `U2L_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n,
        o_out_valid && (o_out_item.kind == KIND_DONE), o_out_item.last)
    `U2L_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_in_stall,
        r_in_valid && o_out_valid)

endmodule
`default_nettype wire

@@ hw/rtl/u2l_step.sv @@
// Per-byte decode: state update and the list of results caused by one byte.
`default_nettype none
module u2l_step
    import u2l_pkg::*;
(
    input  wire t_state                      i_state,
    input  wire t_in_item                    i_item,
    input  wire logic [1:0]                  i_mode,
    output t_state                           o_next,
    output t_out_item [RES_SLOTS-1:0]        o_results,
    output logic [1:0]                       o_count
);

    typedef struct packed {
        logic      emit;
        logic      halt;
        t_out_item item;
    } t_flush;

    function automatic t_flush flush(input logic [31:0] cp, input logic [1:0] mode);
        t_flush f;
        f = '0;
        f.item.kind = KIND_CHAR;
        if (cp <= LATIN1_MAX) begin
            f.emit = 1'b1;
            f.item.out_byte = cp[7:0];
        end else if (cp <= CP_MAX) begin
            if (mode == MODE_STRICT) begin
                f.emit = 1'b1;
                f.halt = 1'b1;
                f.item.kind = KIND_ERROR;
            end else if (mode == MODE_REPLACE) begin
                f.emit = 1'b1;
                f.item.out_byte = QUESTION;
            end
        end
        return f;
    endfunction

    t_state                    st;
    t_flush                    fa;
    t_flush                    fb;
    t_out_item [RES_SLOTS-1:0] res;
    t_out_item                 done_item;
    logic [1:0]                cnt;
    logic [7:0]                b;

    assign b = i_item.in_byte;

    always_comb begin
        st = i_state;
        res = '0;
        cnt = '0;
        fa = flush(i_state.acc, i_mode);
        fb = '0;
        done_item = '0;
        done_item.kind = KIND_DONE;
        if (!st.halted) begin
            if (st.pending && (b[7:6] != 2'b10)) begin
                st.pending = 1'b0;
                if (fa.emit) begin
                    res[cnt] = fa.item;
                    cnt = cnt + 2'd1;
                end
                if (fa.halt) begin
                    st.halted = 1'b1;
                end
            end
            if (!st.halted) begin
                if (b == 8'd0) begin
                    st.halted = 1'b1;
                    st.pending = 1'b0;
                end else begin
                    priority if (b <= 8'h7F) begin
                        st.acc = {24'd0, b};
                    end else if (b <= 8'hBF) begin
                        st.acc = {st.acc[25:0], b[5:0]};
                    end else if (b <= 8'hDF) begin
                        st.acc = {27'd0, b[4:0]};
                    end else if (b <= 8'hEF) begin
                        st.acc = {28'd0, b[3:0]};
                    end else begin
                        st.acc = {29'd0, b[2:0]};
                    end
                    st.pending = 1'b1;
                end
            end
        end
        if (i_item.end_of_string) begin
            fb = flush(st.acc, i_mode);
            if (!st.halted && st.pending && fb.emit) begin
                res[cnt] = fb.item;
                cnt = cnt + 2'd1;
            end
            res[cnt] = done_item;
            cnt = cnt + 2'd1;
            st = '0;
        end
        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last = 1'b1;
        end
    end

    assign o_next    = st;
    assign o_results = res;
    assign o_count   = cnt;

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the UTF-8 to Latin-1 transcoder, with a scoreboard class.
`default_nettype none
module testbench;
    import u2l_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    class latin1_scoreboard;
        t_out_item   expected_q[$];
        logic [1:0]  mode;
        logic [31:0] code_point;
        bit          pending;
        bit          halted;
        int          failures;

        function new();
            mode       = MODE_STRICT;
            code_point = 32'h0;
            pending    = 1'b0;
            halted     = 1'b0;
            failures   = 0;
        endfunction

        function void push_result(logic [7:0] value, t_kind kind);
            t_out_item r;
            r.out_byte = value;
            r.kind     = kind;
            r.last     = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void emit_code_point();
            pending = 1'b0;
            if (code_point > CP_MAX) begin
                return;
            end
            if (code_point <= LATIN1_MAX) begin
                push_result(code_point[7:0], KIND_CHAR);
            end else if (mode == MODE_STRICT) begin
                halted = 1'b1;
                push_result(8'h00, KIND_ERROR);
            end else if (mode == MODE_REPLACE) begin
                push_result(QUESTION, KIND_CHAR);
            end
        endfunction

        function void note_input(t_in_item item);
            int         count_before;
            logic [7:0] b;
            t_out_item  r;
            count_before = expected_q.size();
            b = item.in_byte;
            if (!halted) begin
                if (pending && b[7:6] != 2'b10) begin
                    emit_code_point();
                end
                if (!halted) begin
                    if (b == 8'h00) begin
                        halted  = 1'b1;
                        pending = 1'b0;
                    end else begin
                        if (b <= 8'h7F) begin
                            code_point = {24'h0, b};
                        end else if (b <= 8'hBF) begin
                            code_point = {code_point[25:0], b[5:0]};
                        end else if (b <= 8'hDF) begin
                            code_point = {27'h0, b[4:0]};
                        end else if (b <= 8'hEF) begin
                            code_point = {28'h0, b[3:0]};
                        end else begin
                            code_point = {29'h0, b[2:0]};
                        end
                        pending = 1'b1;
                    end
                end
            end
            if (item.end_of_string) begin
                if (!halted && pending) begin
                    emit_code_point();
                end
                push_result(8'h00, KIND_DONE);
                code_point = 32'h0;
                pending    = 1'b0;
                halted     = 1'b0;
            end
            if (expected_q.size() > count_before) begin
                r = expected_q.pop_back();
                r.last = 1'b1;
                expected_q.push_back(r);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte %02h kind %0d last %0b",
                       got.out_byte, got.kind, got.last);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_data  = 2'd0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    latin1_scoreboard sb = new();
    bit               quiet = 1'b0;
    int               items_sent = 0;
    int               idle_cycles = 0;
    logic [7:0]       string_bytes[$];

    utf8_to_latin1_transcoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 34);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input bit eos);
        t_in_item item;
        item.in_byte       = value;
        item.end_of_string = eos;
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(item);
        items_sent++;
    endtask

    task automatic send_string_bytes();
        for (int i = 0; i < string_bytes.size(); i++) begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
        end
        string_bytes.delete();
    endtask

    task automatic wait_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.mode = mode;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    function automatic void push_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            string_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            string_bytes.push_back({3'b110, cp[10:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            string_bytes.push_back({4'b1110, cp[15:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            string_bytes.push_back({5'b11110, cp[20:18]});
            string_bytes.push_back({2'b10, cp[17:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void add_random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            push_code_point(21'($urandom_range(1, 'h7F)));
        end else if (pick < 56) begin
            push_code_point(21'($urandom_range('h80, 'hFF)));
        end else if (pick < 68) begin
            push_code_point(21'($urandom_range('h100, 'h7FF)));
        end else if (pick < 78) begin
            push_code_point(21'($urandom_range('h800, 'hFFFF)));
        end else if (pick < 86) begin
            push_code_point(21'($urandom_range('h10000, 'h1FFFFF)));
        end else if (pick < 90) begin
            // A multi-byte character cut short by one continuation byte.
            push_code_point(21'($urandom_range('h80, 'hFFFF)));
            void'(string_bytes.pop_back());
        end else if (pick < 98) begin
            string_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            string_bytes.push_back(8'h00);
        end
    endfunction

    initial begin
        logic [1:0] phase_modes[5];
        phase_modes = '{MODE_IGNORE, MODE_REPLACE, MODE_STRICT, MODE_IGNORE, MODE_REPLACE};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        string_bytes = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hC3, 8'hBF};
        send_string_bytes();
        string_bytes = '{8'hE2, 8'h82, 8'hAC, 8'h41, 8'h00};
        send_string_bytes();
        string_bytes = '{8'h00, 8'h41};
        send_string_bytes();
        string_bytes = '{8'h80};
        send_string_bytes();
        string_bytes = '{8'h41, 8'hBF, 8'hBF};
        send_string_bytes();
        string_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'hFF, 8'hDF, 8'hEF, 8'hF0};
        send_string_bytes();
        write_mode(MODE_REPLACE);
        string_bytes = '{8'hE2, 8'h82, 8'hAC, 8'h41};
        send_string_bytes();
        write_mode(MODE_IGNORE);
        string_bytes = '{8'hE2, 8'h82, 8'hAC, 8'h41};
        send_string_bytes();

        for (int p = 0; p < 5; p++) begin
            write_mode(phase_modes[p]);
            quiet = (p == 3);
            while (items_sent < 33 + 38 * (p + 1)) begin
                repeat ($urandom_range(1, 8)) add_random_char();
                send_string_bytes();
                if (p == 1 && $urandom_range(0, 9) == 0) begin
                    wait_drained();
                end
            end
        end
        quiet = 1'b0;

        wait_drained();
        if (sb.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
